// ===== src/timestamp_ordered_resource_grant_queue_core_defines.svh =====
// Assertion macros for the timestamp ordered grant queue.
// Included by the top level; the bodies vanish when SYNTHESIS is defined.
`ifndef TIMESTAMP_ORDERED_RESOURCE_GRANT_QUEUE_CORE_DEFINES_SVH
`define TIMESTAMP_ORDERED_RESOURCE_GRANT_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define TORGQ_CHECK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("torgq check failed");
// same-cycle implication
`define TORGQ_CHECK_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("torgq implication failed");
`else
`define TORGQ_CHECK(lbl, clk, rst_n, prop)
`define TORGQ_CHECK_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/torgq_pkg.sv =====
// Shared types and constants for the timestamp ordered grant queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package torgq_pkg;

	localparam int TS_W        = 32;
	localparam int ID_W        = 8;
	localparam int AMT_W       = 8;
	localparam int BUDGET_W    = 12;
	localparam int SUM_W       = BUDGET_W + 1;
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 12'd20;

	typedef enum logic {
		CMD_ADD     = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// one table entry
	typedef struct packed {
		logic [TS_W-1:0]  ts;
		logic [ID_W-1:0]  id;
		logic [AMT_W-1:0] amt;
		logic             granted;
	} entry_t;

	// results of the shared compare/add unit
	typedef struct packed {
		logic             key_before;
		logic             id_match;
		logic             fits;
		logic [SUM_W-1:0] sum_next;
	} cmp_res_t;

endpackage

`default_nettype wire

// ===== src/timestamp_ordered_resource_grant_queue_core.sv =====
// Timestamp ordered resource grant queue. A table of requests is kept sorted by
// (timestamp, requester id). An add beat inserts a request, a release beat removes
// the first entry with that id; then the table is scanned from the front, summing
// amounts while within the budget, and each newly granted entry yields one output
// beat (at most 16 per input, last marks the final one; one empty beat if none).
// One input beat at a time: in_ready is high only when idle. Every table entry
// touched takes a read state and an evaluate state, since the single table read
// port has registered data: an add walks the entries behind the new one, a release
// every entry, and the grant scan the entries it walks; output stalls add to this.
// No clearing pass.
// Depends on torgq_pkg, torgq_table, torgq_unit and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_ordered_resource_grant_queue_core_defines.svh"

module timestamp_ordered_resource_grant_queue_core
	import torgq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [BUDGET_W-1:0] cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [TS_W-1:0]     timestamp,
	input  logic [ID_W-1:0]     requester_id,
	input  logic [AMT_W-1:0]    amount,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                grant_valid,
	output logic [ID_W-1:0]     granted_id,
	output logic [1:0]          status,
	output logic                last
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_EV,
		S_REL_RD,
		S_REL_EV,
		S_SCAN_RD,
		S_SCAN_EV,
		S_FLUSH
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     idx_q;
	logic [BUDGET_W-1:0]  budget_q;
	logic [BUDGET_W-1:0]  sum_q;
	logic [RES_CNT_W-1:0] n_q;
	logic                 found_q;
	logic                 pend_q;
	logic [ID_W-1:0]      pend_id_q;
	status_t              cmd_status_q;
	logic [TS_W-1:0]      ts_q;
	logic [ID_W-1:0]      id_q;
	logic [AMT_W-1:0]     amt_q;
	logic                 out_valid_q;
	logic                 out_gv_q;
	logic [ID_W-1:0]      out_id_q;
	status_t              out_status_q;
	logic                 out_last_q;

	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	entry_t               rd_data;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	entry_t               wr_data;
	entry_t               new_entry;
	cmp_res_t             cmp;
	logic [CNT_W-1:0]     idx_m1;
	logic                 out_free;
	logic                 scan_done;
	logic                 grant_go;
	logic                 out_load;

	torgq_table #(
		.DEPTH (QUEUE_DEPTH)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	torgq_unit u_unit (
		.key_ts (ts_q),
		.key_id (id_q),
		.ent    (rd_data),
		.sum    (sum_q),
		.budget (budget_q),
		.res    (cmp)
	);

	assign new_entry = '{ts: ts_q, id: id_q, amt: amt_q, granted: 1'b0};
	assign idx_m1    = idx_q - 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign scan_done = (idx_q == cnt_q) || (n_q == RES_CNT_W'(MAX_RESULTS));
	// a new grant can retire once the held grant has a free output slot
	assign grant_go  = cmp.fits && !rd_data.granted && (!pend_q || out_free);
	// output register takes a new beat this cycle
	assign out_load  = ((state_q == S_SCAN_EV) && grant_go && pend_q) ||
		((state_q == S_FLUSH) && out_free);

	// table port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_data;
		unique case (state_q)
			S_ADD_RD: begin
				if (idx_q == '0) begin
					wr_en   = 1'b1;
					wr_data = new_entry;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_m1[IDX_W-1:0];
				end
			end
			S_ADD_EV: begin
				// shift the entry up one slot, or drop the new one in here
				wr_en   = 1'b1;
				wr_data = cmp.key_before ? rd_data : new_entry;
			end
			S_REL_RD: begin
				rd_en = (idx_q != cnt_q);
			end
			S_REL_EV: begin
				// entries behind the removed one move down one slot
				wr_en   = found_q;
				wr_addr = idx_m1[IDX_W-1:0];
			end
			S_SCAN_RD: begin
				rd_en = !scan_done;
			end
			S_SCAN_EV: begin
				wr_en           = grant_go;
				wr_data.granted = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer, table count, budget register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			budget_q     <= BUDGET_RESET;
			sum_q        <= '0;
			n_q          <= '0;
			found_q      <= 1'b0;
			pend_q       <= 1'b0;
			pend_id_q    <= '0;
			cmd_status_q <= ST_OK;
			ts_q         <= '0;
			id_q         <= '0;
			amt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_gv_q     <= 1'b0;
			out_id_q     <= '0;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				budget_q <= cfg_data;
			end
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ts_q         <= timestamp;
						id_q         <= requester_id;
						amt_q        <= amount;
						if (cmd_t'(command) == CMD_RELEASE) begin
							cmd_status_q <= ST_OK;
							idx_q        <= '0;
							found_q      <= 1'b0;
							state_q      <= S_REL_RD;
						end else if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
							cmd_status_q <= ST_FULL;
							idx_q        <= '0;
							sum_q        <= '0;
							n_q          <= '0;
							pend_q       <= 1'b0;
							state_q      <= S_SCAN_RD;
						end else begin
							cmd_status_q <= ST_OK;
							idx_q        <= cnt_q;
							state_q      <= S_ADD_RD;
						end
					end
				end
				S_ADD_RD: begin
					if (idx_q == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						sum_q   <= '0;
						n_q     <= '0;
						pend_q  <= 1'b0;
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_ADD_EV;
					end
				end
				S_ADD_EV: begin
					if (cmp.key_before) begin
						idx_q   <= idx_m1;
						state_q <= S_ADD_RD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						idx_q   <= '0;
						sum_q   <= '0;
						n_q     <= '0;
						pend_q  <= 1'b0;
						state_q <= S_SCAN_RD;
					end
				end
				S_REL_RD: begin
					if (idx_q == cnt_q) begin
						if (found_q) begin
							cnt_q <= cnt_q - 1'b1;
						end else begin
							cmd_status_q <= ST_NOT_FOUND;
						end
						idx_q   <= '0;
						sum_q   <= '0;
						n_q     <= '0;
						pend_q  <= 1'b0;
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_REL_EV;
					end
				end
				S_REL_EV: begin
					if (!found_q && cmp.id_match) begin
						found_q <= 1'b1;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= S_REL_RD;
				end
				S_SCAN_RD: begin
					state_q <= scan_done ? S_FLUSH : S_SCAN_EV;
				end
				S_SCAN_EV: begin
					if (!cmp.fits) begin
						state_q <= S_FLUSH;
					end else if (rd_data.granted) begin
						sum_q   <= cmp.sum_next[BUDGET_W-1:0];
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end else if (grant_go) begin
						// the held grant is not the last one: send it now
						if (pend_q) begin
							out_valid_q  <= 1'b1;
							out_gv_q     <= 1'b1;
							out_id_q     <= pend_id_q;
							out_status_q <= cmd_status_q;
							out_last_q   <= 1'b0;
						end
						pend_q    <= 1'b1;
						pend_id_q <= rd_data.id;
						sum_q     <= cmp.sum_next[BUDGET_W-1:0];
						n_q       <= n_q + 1'b1;
						idx_q     <= idx_q + 1'b1;
						state_q   <= S_SCAN_RD;
					end
				end
				S_FLUSH: begin
					// final beat: held grant, or an empty result
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_gv_q     <= pend_q;
						out_id_q     <= pend_q ? pend_id_q : '0;
						out_status_q <= cmd_status_q;
						out_last_q   <= 1'b1;
						pend_q       <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign grant_valid = out_gv_q;
	assign granted_id  = out_id_q;
	assign status      = out_status_q;
	assign last        = out_last_q;

	// checks
	`TORGQ_CHECK(a_cnt_le_depth, clk, arst_n, cnt_q <= CNT_W'(QUEUE_DEPTH))
	`TORGQ_CHECK_IMP(a_empty_is_last, clk, arst_n, out_valid_q && !out_gv_q, out_last_q && (out_id_q == '0))
	`TORGQ_CHECK_IMP(a_grants_capped, clk, arst_n, state_q == S_SCAN_EV, n_q < RES_CNT_W'(MAX_RESULTS))
	`TORGQ_CHECK_IMP(a_idle_no_held, clk, arst_n, state_q == S_IDLE, !pend_q)

endmodule

`default_nettype wire

// ===== src/torgq_table.sv =====
// Entry storage: one write port, one registered read port.
// Depends on torgq_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module torgq_table
	import torgq_pkg::*;
#(
	parameter int DEPTH = 16,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== src/torgq_unit.sv =====
// Shared compare/add unit: order key compare, id match, budget check.
// Depends on torgq_pkg for entry and result types.
`timescale 1ns / 1ps
`default_nettype none

module torgq_unit
	import torgq_pkg::*;
(
	input  logic [TS_W-1:0]     key_ts,
	input  logic [ID_W-1:0]     key_id,
	input  entry_t              ent,
	input  logic [BUDGET_W-1:0] sum,
	input  logic [BUDGET_W-1:0] budget,
	output cmp_res_t            res
);

	always_comb begin
		// new key sorts strictly before the entry
		res.key_before = (key_ts < ent.ts) || ((key_ts == ent.ts) && (key_id < ent.id));
		res.id_match   = (key_id == ent.id);
		// running sum plus this entry, checked against the budget
		res.sum_next   = {1'b0, sum} + {{(SUM_W - AMT_W){1'b0}}, ent.amt};
		res.fits       = (res.sum_next <= {1'b0, budget});
	end

endmodule

`default_nettype wire

// ===== verif/tb_timestamp_ordered_resource_grant_queue_core.sv =====
// Self-checking testbench for timestamp_ordered_resource_grant_queue_core: directed and
// random add/release beats against an in-bench model of the ordered request table.
// Depends on torgq_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_timestamp_ordered_resource_grant_queue_core;
	import torgq_pkg::*;

	localparam int TABLE_DEPTH = 16;
	// final drain wait, sized from the table depth
	localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + 16;
	localparam int RUN_LIMIT_NS = 1_000_000;

	// one expected output beat
	typedef struct packed {
		logic            gv;
		logic [ID_W-1:0] id;
		status_t         st;
		logic            fin;
	} grant_beat_t;

	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [BUDGET_W-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	cmd_t                command;
	logic [TS_W-1:0]     timestamp;
	logic [ID_W-1:0]     requester_id;
	logic [AMT_W-1:0]    amount;
	logic                out_valid;
	logic                out_ready;
	logic                grant_valid;
	logic [ID_W-1:0]     granted_id;
	logic [1:0]          status;
	logic                last;

	timestamp_ordered_resource_grant_queue_core #(
		.QUEUE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.timestamp(timestamp),
		.requester_id(requester_id),
		.amount(amount),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.grant_valid(grant_valid),
		.granted_id(granted_id),
		.status(status),
		.last(last)
	);

	// request table model, kept sorted by (ts, id)
	entry_t              held_req [TABLE_DEPTH];
	int unsigned         held_count;
	logic [BUDGET_W-1:0] budget_setting;
	grant_beat_t         expected_grants [$];

	// stimulus pacing
	int unsigned  request_gap;
	int unsigned  burst_left;
	bit           sender_bursty;
	logic [TS_W-1:0] ts_counter;

	int unsigned errors;
	int unsigned requests_sent;
	int unsigned grants_seen;
	int unsigned full_seen;
	int unsigned not_found_seen;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout at %0t ns with %0d beats still expected", $time,
			expected_grants.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// apply one command to the table model and queue the beats it should produce
	function automatic void predict_grants(cmd_t cmd, logic [TS_W-1:0] ts,
			logic [ID_W-1:0] id, logic [AMT_W-1:0] amt);
		status_t     st;
		int          pos;
		int unsigned sum;
		int          n;
		bit          stop;
		grant_beat_t b;
		st = ST_OK;
		pos = 0;
		sum = 0;
		n = 0;
		stop = 1'b0;
		if (cmd == CMD_ADD) begin
			if (held_count >= TABLE_DEPTH) begin
				st = ST_FULL;
			end else begin
				// equal keys land behind the existing entry
				while (pos < held_count && !(ts < held_req[pos].ts ||
						(ts == held_req[pos].ts && id < held_req[pos].id)))
					pos++;
				for (int i = held_count; i > pos; i--)
					held_req[i] = held_req[i - 1];
				held_req[pos].ts = ts;
				held_req[pos].id = id;
				held_req[pos].amt = amt;
				held_req[pos].granted = 1'b0;
				held_count++;
			end
		end else begin
			while (pos < held_count && held_req[pos].id != id)
				pos++;
			if (pos >= held_count) begin
				st = ST_NOT_FOUND;
			end else begin
				for (int i = pos; i + 1 < held_count; i++)
					held_req[i] = held_req[i + 1];
				held_count--;
			end
		end
		// grant scan over the prefix that fits the budget
		for (int i = 0; i < held_count && n < MAX_RESULTS && !stop; i++) begin
			if (sum + held_req[i].amt > budget_setting) begin
				stop = 1'b1;
			end else begin
				sum += held_req[i].amt;
				if (!held_req[i].granted) begin
					held_req[i].granted = 1'b1;
					b.gv = 1'b1;
					b.id = held_req[i].id;
					b.st = st;
					b.fin = 1'b0;
					expected_grants.push_back(b);
					n++;
				end
			end
		end
		if (n == 0) begin
			b.gv = 1'b0;
			b.id = '0;
			b.st = st;
			b.fin = 1'b1;
			expected_grants.push_back(b);
		end else begin
			expected_grants[expected_grants.size() - 1].fin = 1'b1;
		end
	endfunction

	function automatic void flag_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			errors++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin : beat_check
		grant_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_grants.size() == 0) begin
				$display("%0t ns: unexpected beat, expected none, actual id %0h status %0d",
					$time, granted_id, status);
				errors++;
			end else begin
				want = expected_grants.pop_front();
				flag_field("grant_valid", want.gv, grant_valid);
				flag_field("granted_id", want.id, granted_id);
				flag_field("status", want.st, status);
				flag_field("last", want.fin, last);
				if (want.gv)
					grants_seen++;
				if (want.fin && want.st == ST_FULL)
					full_seen++;
				if (want.fin && want.st == ST_NOT_FOUND)
					not_found_seen++;
			end
		end
	end

	// result backpressure, switching between patterns
	initial begin : ready_pattern
		ready_mode_t mode;
		int unsigned span;
		int unsigned hold;
		out_ready = 1'b0;
		mode = RDY_ALWAYS;
		span = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = ready_mode_t'($urandom_range(0, 3));
				span = $urandom_range(20, 120);
			end
			span--;
			case (mode)
				RDY_ALWAYS: out_ready <= 1'b1;
				RDY_COIN: out_ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: begin
					// long stalls broken by single open cycles
					if (hold == 0) begin
						out_ready <= 1'b1;
						hold = $urandom_range(1, 7);
					end else begin
						out_ready <= 1'b0;
						hold--;
					end
				end
				default: out_ready <= (span % 5) < 2;
			endcase
		end
	end

	// drive one request beat and wait for it to be taken
	task automatic send_request(cmd_t cmd, logic [TS_W-1:0] ts, logic [ID_W-1:0] id,
			logic [AMT_W-1:0] amt);
		repeat (request_gap) @(negedge clk);
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		timestamp <= ts;
		requester_id <= id;
		amount <= amt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_grants(cmd, ts, id, amt);
		requests_sent++;
		// spacing to the next beat: back to back inside a burst
		request_gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else if (sender_bursty) begin
			burst_left = $urandom_range(0, 6);
			request_gap = $urandom_range(1, 10);
		end
		if (request_gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			request_gap--;
		end
	endtask

	// stop sending and wait for every outstanding beat
	task automatic drain_results();
		if (in_valid) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		request_gap = 0;
		while (expected_grants.size() != 0) @(posedge clk);
	endtask

	task automatic write_budget(logic [BUDGET_W-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		budget_setting = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// release on an empty table right after reset
	task automatic test_release_empty();
		send_request(CMD_RELEASE, '0, '0, '0);
	endtask

	// key order, equal-key stability and field extremes under the reset budget
	task automatic test_key_order();
		send_request(CMD_ADD, 32'd5, 8'd3, 8'd0);
		send_request(CMD_ADD, 32'd5, 8'd3, 8'd255);
		send_request(CMD_ADD, 32'd5, 8'd1, 8'd20);
		send_request(CMD_ADD, 32'd0, 8'd255, 8'd7);
		send_request(CMD_ADD, 32'hFFFF_FFFF, 8'd0, 8'd1);
		send_request(CMD_RELEASE, 32'hFFFF_FFFF, 8'd3, 8'd255);
		send_request(CMD_RELEASE, 32'd0, 8'd200, 8'd0);
	endtask

	// raised budget granted by a failed release; zero budget passes only zero amounts
	task automatic test_budget_extremes();
		write_budget('1);
		send_request(CMD_RELEASE, 32'd9, 8'd201, 8'd0);
		write_budget('0);
		send_request(CMD_ADD, 32'd0, 8'd0, 8'd0);
	endtask

	// fill the table and then overflow it
	task automatic test_table_full();
		while (held_count < TABLE_DEPTH) begin
			ts_counter = ts_counter + $urandom_range(0, 3);
			send_request(CMD_ADD, ts_counter, ID_W'($urandom_range(0, 255)),
				AMT_W'($urandom_range(0, 255)));
		end
		send_request(CMD_ADD, ts_counter, 8'd42, 8'd5);
	endtask

	// random traffic: mostly well-formed releases of held ids, ties and small amounts
	task automatic test_random_traffic(logic [BUDGET_W-1:0] budget, int unsigned n_items,
			int unsigned add_pct, bit bursty);
		cmd_t             cmd;
		logic [TS_W-1:0]  ts;
		logic [ID_W-1:0]  id;
		logic [AMT_W-1:0] amt;
		write_budget(budget);
		sender_bursty = bursty;
		for (int k = 0; k < n_items; k++) begin
			cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_RELEASE;
			case ($urandom_range(0, 9))
				0: ts = $urandom;
				1: ts = 32'hFFFF_FFFF - $urandom_range(0, 2);
				2: ts = $urandom_range(0, 2);
				3: ts = (held_count > 0) ? held_req[$urandom_range(0, held_count - 1)].ts
					: ts_counter;
				default: begin
					ts_counter = ts_counter + $urandom_range(0, 2);
					ts = ts_counter;
				end
			endcase
			id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 255))
				: ID_W'($urandom_range(0, 7));
			if (cmd == CMD_RELEASE && held_count > 0 && $urandom_range(0, 9) < 8)
				id = held_req[$urandom_range(0, held_count - 1)].id;
			amt = ($urandom_range(0, 9) < 7) ? AMT_W'($urandom_range(0, 12))
				: AMT_W'($urandom_range(0, 255));
			send_request(cmd, ts, id, amt);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_ADD;
		timestamp = '0;
		requester_id = '0;
		amount = '0;
		held_count = 0;
		budget_setting = BUDGET_RESET;
		request_gap = 0;
		burst_left = 0;
		sender_bursty = 1'b1;
		ts_counter = 32'd10;
		errors = 0;
		requests_sent = 0;
		grants_seen = 0;
		full_seen = 0;
		not_found_seen = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_release_empty();
		test_key_order();
		test_budget_extremes();
		test_table_full();
		test_random_traffic(BUDGET_RESET, 30, 60, 1'b1);
		test_random_traffic('1, 30, 70, 1'b0);
		test_random_traffic(BUDGET_W'($urandom_range(21, 80)), 30, 50, 1'b1);
		test_random_traffic('0, 20, 50, 1'b1);
		test_random_traffic(BUDGET_W'($urandom_range(0, 4095)), 20, 55, 1'b0);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests over a range of budget settings; saw %0d grants,",
			requests_sent, grants_seen);
		$display("%0d table-full drops and %0d releases with no match.", full_seen,
			not_found_seen);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
